// File: sv/cubic_congestion_window_top_assert.svh
// Assertion macros for the CUBIC congestion window block.
// Used by the port checker; needs i_clk and i_rst_n in the including scope.
`ifndef CUBIC_CONGESTION_WINDOW_TOP_ASSERT_SVH
`define CUBIC_CONGESTION_WINDOW_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CCW_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define CCW_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that is checked during reset as well.
`define CCW_ASSERT_ALWAYS(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/ccw_pkg.sv
// Package for the CUBIC congestion window block: constants, codes and types.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package ccw_pkg;

    localparam int CBRT_ITERATIONS = 16;
    localparam int ITER_W          = $clog2(CBRT_ITERATIONS);

    localparam logic [31:0] ONE_Q16      = 32'h0001_0000;
    localparam logic [31:0] TWO_Q16      = 32'h0002_0000;
    localparam logic [31:0] MAX32        = 32'hFFFF_FFFF;
    localparam logic [22:0] TK_CLAMP     = 23'h40_0000;
    localparam logic [31:0] TICK_RESET   = 32'd1000000000;

    // Reciprocals for division by 3 (shift 33), by 5 (shift 34) and by 10 (shift 35).
    localparam logic [31:0] RECIP3       = 32'hAAAA_AAAB;
    localparam logic [31:0] RECIP5       = 32'hCCCC_CCCD;
    // floor(2^32 / 5); 2^32 leaves a remainder of one when divided by 5.
    localparam logic [31:0] FIFTH32      = 32'h3333_3333;

    // Result region codes.
    typedef enum logic [1:0] {
        RG_SLOW     = 2'd0,
        RG_FRIENDLY = 2'd1,
        RG_CUBIC    = 2'd2,
        RG_DECREASE = 2'd3
    } t_region;

    // Sequencer states.
    typedef enum logic [4:0] {
        ST_IDLE,
        ST_DWAIT,
        ST_D_INIT,
        ST_D_SQ,
        ST_D_NDIV,
        ST_D_SUM,
        ST_D_NEXT,
        ST_D_SCALE,
        ST_D_FIN,
        ST_C_DT,
        ST_C_WHOLE,
        ST_C_FRAC,
        ST_C_TK,
        ST_C_SQ,
        ST_C_CUBE,
        ST_C_WC,
        ST_C_BASE,
        ST_C_FQ,
        ST_C_FR,
        ST_C_CMP,
        ST_C_STEP,
        ST_DONE
    } t_state;

    // Request to the shared divider.
    typedef struct packed {
        logic        start;
        logic [63:0] num;
        logic [63:0] den;
    } t_div_req;

    // Response of the shared divider.
    typedef struct packed {
        logic        done;
        logic [63:0] quot;
        logic [63:0] rem;
    } t_div_rsp;

endpackage

// File: sv/ccw_div.sv
// Radix-2 restoring divider, 64-bit numerator and divisor, one bit per cycle.
// Depends on ccw_pkg for the request and response types.
`timescale 1ns / 1ps

module ccw_div
    import ccw_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    logic [64:0] r_rem, n_rem;
    logic [63:0] r_quo, n_quo;
    logic [63:0] r_den, n_den;
    logic [5:0]  r_cnt, n_cnt;
    logic        r_busy, n_busy;
    logic        r_done, n_done;
    logic [64:0] w_shift;
    logic [64:0] w_diff;

    // One shift-and-subtract step per cycle.
    always_comb begin
        n_rem  = r_rem;
        n_quo  = r_quo;
        n_den  = r_den;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        w_shift = {r_rem[63:0], r_quo[63]};
        w_diff  = w_shift - {1'b0, r_den};
        if (i_req.start) begin
            n_rem  = '0;
            n_quo  = i_req.num;
            n_den  = i_req.den;
            n_cnt  = '0;
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (w_shift >= {1'b0, r_den}) begin
                n_rem = w_diff;
                n_quo = {r_quo[62:0], 1'b1};
            end else begin
                n_rem = w_shift;
                n_quo = {r_quo[62:0], 1'b0};
            end
            n_cnt = r_cnt + 6'd1;
            if (r_cnt == 6'd63) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_den <= n_den;
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quo;
    assign o_rsp.rem  = r_rem[63:0];

endmodule

// File: sv/ccw_mul.sv
// Shared 32x32 multiplier with a registered product, loaded on enable.
// Depends on ccw_pkg only by convention of the block.
`timescale 1ns / 1ps

module ccw_mul
    import ccw_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [31:0] i_a,
    input  logic [31:0] i_b,
    output logic [63:0] o_p
);

    logic [63:0] r_p;

    // The product holds until the next enabled multiply.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p <= i_a * i_b;
        end
    end

    assign o_p = r_p;

endmodule

// File: sv/cubic_congestion_window_top.sv
// CUBIC congestion window: an accepted input beat in slow start goes straight to the done
// state; an increase outside slow start takes up to five divides and a decrease up to 16
// cube root steps of one divide each. A divide holds the sequencer in its wait state.
// One item at a time: the next input beat is taken no earlier than the first edge at
// which the result beat of the last one can be taken.
// Synchronous active-low reset: window 2.0, slow start limit all ones, tick rate 1e9.
`timescale 1ns / 1ps

module cubic_congestion_window_top
    import ccw_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic [31:0]  i_cfg_wdata,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [95:0]  s_axis_tdata,  // now_ticks [63:0], srtt_ticks [95:64]
    input  logic [0:0]   s_axis_tuser,  // mode [0]
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [31:0]  m_axis_tdata,  // window [31:0]
    output logic [1:0]   m_axis_tuser   // region [1:0]
);

    t_state      r_state, n_state;
    t_state      r_ret, n_ret;
    logic [63:0] r_now, n_now;
    logic [31:0] r_srtt, n_srtt;
    logic [31:0] r_tick, n_tick;
    logic [63:0] r_epoch, n_epoch;
    logic [31:0] r_cur, n_cur;
    logic [31:0] r_wmax, n_wmax;
    logic [31:0] r_k, n_k;
    logic [31:0] r_ssl, n_ssl;
    logic [63:0] r_dt, n_dt;
    logic [31:0] r_nh, n_nh;
    logic [22:0] r_y, n_y;
    logic [ITER_W-1:0] r_iter, n_iter;
    logic        r_upd, n_upd;
    logic [48:0] r_tq, n_tq;
    logic        r_neg, n_neg;
    logic [22:0] r_a, n_a;
    logic [31:0] r_s2, n_s2;
    logic [2:0]  r_qh, n_qh;
    logic [31:0] r_wc, n_wc;
    logic [31:0] r_base, n_base;
    logic [15:0] r_fq, n_fq;
    logic [31:0] r_we, n_we;
    t_region     r_region, n_region;
    logic        r_ov, n_ov;
    logic [31:0] r_ow, n_ow;
    t_region     r_or, n_or;

    t_div_req    w_dreq;
    t_div_rsp    w_drsp;
    logic        w_men;
    logic [31:0] w_ma, w_mb;
    logic [63:0] w_prod;

    // Datapath temporaries.
    logic [33:0] w_cur3;
    logic [31:0] w_m;
    logic [5:0]  w_lz;
    logic [6:0]  w_bits;
    logic [15:0] w_emul;
    logic [22:0] w_ynew;
    logic [31:0] w_sum3;
    logic [31:0] w_sev_src;
    logic [28:0] w_q10;
    logic [3:0]  w_r10;
    logic [31:0] w_sev;
    logic [34:0] w_cube;
    logic [32:0] w_s33;
    logic [31:0] w_s2;
    logic [29:0] w_q5;
    logic [2:0]  w_r5;
    logic [34:0] w_q5t;
    logic [36:0] w_den17;
    logic [31:0] w_rate;
    logic [40:0] w_rem9;
    logic [19:0] w_fq9;
    logic [48:0] w_kz;
    logic [48:0] w_tkmag;
    logic [34:0] w_term;
    logic [35:0] w_wcsum;
    logic [36:0] w_fterm;
    logic [37:0] w_wesum;
    logic [31:0] w_diff;
    logic [48:0] w_mag;
    logic [49:0] w_stsum;
    logic [31:0] w_q32;

    // Seven tenths of a remainder below ten, rounded down.
    function automatic logic [2:0] f_frac7(input logic [3:0] rem);
        case (rem)
            4'd0:    f_frac7 = 3'd0;
            4'd1:    f_frac7 = 3'd0;
            4'd2:    f_frac7 = 3'd1;
            4'd3:    f_frac7 = 3'd2;
            4'd4:    f_frac7 = 3'd2;
            4'd5:    f_frac7 = 3'd3;
            4'd6:    f_frac7 = 3'd4;
            4'd7:    f_frac7 = 3'd4;
            4'd8:    f_frac7 = 3'd5;
            4'd9:    f_frac7 = 3'd6;
            default: f_frac7 = 3'd0;
        endcase
    endfunction

    ccw_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_dreq),
        .o_rsp   (w_drsp)
    );

    ccw_mul u_mul (
        .i_clk (i_clk),
        .i_en  (w_men),
        .i_a   (w_ma),
        .i_b   (w_mb),
        .o_p   (w_prod)
    );

    // Fixed scalings by small constants, done with shifts and adds.
    always_comb begin
        w_cur3  = {2'b0, r_cur} + {1'b0, r_cur, 1'b0};
        w_m     = w_cur3[33:2];
        w_den17 = {1'b0, r_srtt, 4'b0} + {5'b0, r_srtt};
        w_rate  = (r_tick == 32'd0) ? 32'd1 : r_tick;
        w_rem9  = {w_drsp.rem[36:0], 3'b0} + {4'b0, w_drsp.rem[36:0]};
        w_fq9   = {1'b0, r_fq, 3'b0} + {4'b0, r_fq};
        w_kz    = {17'b0, r_k};
        w_q32   = w_drsp.quot[31:0];
    end

    // Seven tenths of the window or of the maximum, from the product by the
    // reciprocal of ten: 7 * (x / 10) plus seven tenths of the remainder.
    always_comb begin
        w_sev_src = (r_state == ST_D_FIN) ? r_cur : r_wmax;
        w_q10     = w_prod[63:35];
        w_r10     = w_sev_src[3:0] - ({w_q10[0], 3'b0} + {w_q10[2:0], 1'b0});
        w_sev     = ({w_q10, 3'b0} - {3'b0, w_q10}) + {29'b0, f_frac7(w_r10)};
    end

    // Bit length of the cube root argument, and the starting guess 2^ceil(bits/3).
    always_comb begin
        w_lz = '0;
        for (int i = 0; i < 32; i++) begin
            if (w_m[i]) begin
                w_lz = 6'(i + 1);
            end
        end
        w_bits = 7'(w_lz) + 7'd34;
        w_emul = 16'(w_bits) * 16'd171;
    end

    // Sequencer: next state, datapath updates and unit requests.
    always_comb begin
        n_state  = r_state;
        n_ret    = r_ret;
        n_now    = r_now;
        n_srtt   = r_srtt;
        n_tick   = r_tick;
        n_epoch  = r_epoch;
        n_cur    = r_cur;
        n_wmax   = r_wmax;
        n_k      = r_k;
        n_ssl    = r_ssl;
        n_dt     = r_dt;
        n_nh     = r_nh;
        n_y      = r_y;
        n_iter   = r_iter;
        n_upd    = r_upd;
        n_tq     = r_tq;
        n_neg    = r_neg;
        n_a      = r_a;
        n_s2     = r_s2;
        n_qh     = r_qh;
        n_wc     = r_wc;
        n_base   = r_base;
        n_fq     = r_fq;
        n_we     = r_we;
        n_region = r_region;
        n_ov     = r_ov;
        n_ow     = r_ow;
        n_or     = r_or;
        w_dreq   = '0;
        w_men    = 1'b0;
        w_ma     = '0;
        w_mb     = '0;
        w_ynew   = r_y;
        w_sum3   = '0;
        w_cube   = '0;
        w_s33    = '0;
        w_s2     = '0;
        w_q5     = '0;
        w_r5     = '0;
        w_q5t    = '0;
        w_tkmag  = '0;
        w_term   = '0;
        w_wcsum  = '0;
        w_fterm  = '0;
        w_wesum  = '0;
        w_diff   = '0;
        w_mag    = '0;
        w_stsum  = '0;

        if (i_cfg_we) begin
            n_tick = i_cfg_wdata;
        end
        if (r_ov && m_axis_tready) begin
            n_ov = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (s_axis_tvalid) begin
                    n_now  = s_axis_tdata[63:0];
                    n_srtt = s_axis_tdata[95:64];
                    if (s_axis_tuser[0]) begin
                        n_state = ST_D_INIT;
                    end else if (r_cur < r_ssl) begin
                        n_cur    = (r_cur > MAX32 - ONE_Q16) ? MAX32 : r_cur + ONE_Q16;
                        n_region = RG_SLOW;
                        n_state  = ST_DONE;
                    end else begin
                        n_state = ST_C_DT;
                    end
                end
            end

            ST_DWAIT: begin
                if (w_drsp.done) begin
                    n_state = r_ret;
                end
            end

            // Decrease: record the maximum and start the cube root.
            ST_D_INIT: begin
                n_wmax  = r_cur;
                n_epoch = r_now;
                n_nh    = w_m;
                if (w_m == 32'd0) begin
                    n_k     = '0;
                    n_state = ST_D_SCALE;
                end else begin
                    n_y     = 23'd1 << w_emul[13:9];
                    n_iter  = '0;
                    n_state = ST_D_SQ;
                end
            end

            ST_D_SQ: begin
                w_men   = 1'b1;
                w_ma    = 32'(r_y);
                w_mb    = 32'(r_y);
                n_state = ST_D_NDIV;
            end

            ST_D_NDIV: begin
                w_dreq.start = 1'b1;
                w_dreq.num   = {r_nh, 32'b0};
                w_dreq.den   = w_prod;
                n_ret        = ST_D_SUM;
                n_state      = ST_DWAIT;
            end

            // The step can only lower the guess when n / y^2 is below y; then the
            // sum 2y + n / y^2 is small and is divided by 3 on the multiplier.
            ST_D_SUM: begin
                if (w_drsp.quot < {41'b0, r_y}) begin
                    w_sum3 = {8'b0, r_y, 1'b0} + w_drsp.quot[31:0];
                    w_men  = 1'b1;
                    w_ma   = w_sum3;
                    w_mb   = RECIP3;
                    n_upd  = 1'b1;
                end else begin
                    n_upd  = 1'b0;
                end
                n_state = ST_D_NEXT;
            end

            // Newton step only moves the guess downward and never to zero.
            ST_D_NEXT: begin
                if (r_upd && w_prod[55:33] != 23'd0) begin
                    w_ynew = w_prod[55:33];
                end
                n_y = w_ynew;
                if (r_iter == ITER_W'(CBRT_ITERATIONS - 1)) begin
                    n_k     = 32'(w_ynew);
                    n_state = ST_D_SCALE;
                end else begin
                    n_iter  = r_iter + 1'b1;
                    n_state = ST_D_SQ;
                end
            end

            ST_D_SCALE: begin
                w_men   = 1'b1;
                w_ma    = r_cur;
                w_mb    = RECIP5;
                n_state = ST_D_FIN;
            end

            ST_D_FIN: begin
                n_cur    = w_sev;
                n_ssl    = (w_sev > TWO_Q16) ? w_sev : TWO_Q16;
                n_region = RG_DECREASE;
                n_state  = ST_DONE;
            end

            // Increase outside slow start: elapsed time in Q32.16 seconds.
            ST_C_DT: begin
                n_dt         = r_now - r_epoch;
                w_dreq.start = 1'b1;
                w_dreq.num   = r_now - r_epoch;
                w_dreq.den   = 64'(w_rate);
                n_ret        = ST_C_WHOLE;
                n_state      = ST_DWAIT;
            end

            ST_C_WHOLE: begin
                if (w_drsp.quot[63:32] != 32'd0) begin
                    n_tq    = 49'd1 << 48;
                    n_state = ST_C_TK;
                end else begin
                    n_tq         = {1'b0, w_q32, 16'b0};
                    w_dreq.start = 1'b1;
                    w_dreq.num   = {w_drsp.rem[47:0], 16'b0};
                    w_dreq.den   = 64'(w_rate);
                    n_ret        = ST_C_FRAC;
                    n_state      = ST_DWAIT;
                end
            end

            ST_C_FRAC: begin
                n_tq    = r_tq + 49'(w_drsp.quot[15:0]);
                n_state = ST_C_TK;
            end

            // Magnitude of t - K, clamped, then squared.
            ST_C_TK: begin
                if (r_tq >= w_kz) begin
                    w_tkmag = r_tq - w_kz;
                    n_neg   = 1'b0;
                end else begin
                    w_tkmag = w_kz - r_tq;
                    n_neg   = 1'b1;
                end
                n_a     = (w_tkmag > 49'(TK_CLAMP)) ? TK_CLAMP : w_tkmag[22:0];
                w_men   = 1'b1;
                w_ma    = (w_tkmag > 49'(TK_CLAMP)) ? 32'(TK_CLAMP) : 32'(w_tkmag[22:0]);
                w_mb    = w_ma;
                n_state = ST_C_SQ;
            end

            ST_C_SQ: begin
                w_men   = 1'b1;
                w_ma    = w_prod[47:16];
                w_mb    = 32'(r_a);
                n_state = ST_C_CUBE;
            end

            // Fold the cube, at most 2^34, into 32 bits modulo 5, since 2^32 is
            // one more than a multiple of 5, then divide the folded part by 5.
            ST_C_CUBE: begin
                w_cube  = w_prod[50:16];
                w_s33   = {1'b0, w_cube[31:0]} + {30'b0, w_cube[34:32]};
                w_s2    = w_s33[31:0] + {31'b0, w_s33[32]};
                n_qh    = w_cube[34:32] + {2'b0, w_s33[32]};
                n_s2    = w_s2;
                w_men   = 1'b1;
                w_ma    = w_s2;
                w_mb    = RECIP5;
                n_state = ST_C_WC;
            end

            // Cubic target, then the base of the friendly estimate.
            ST_C_WC: begin
                w_q5   = w_prod[63:34];
                w_r5   = r_s2[2:0] - ({w_q5[0], 2'b0} + w_q5[2:0]);
                w_q5t  = {32'b0, r_qh} * {3'b0, FIFTH32} + {5'b0, w_q5};
                w_term = {w_q5t[33:0], 1'b0} + {34'b0, (w_r5 >= 3'd3)};
                if (r_neg) begin
                    n_wc = (w_term > {3'b0, r_wmax}) ? 32'd0 : r_wmax - w_term[31:0];
                end else begin
                    w_wcsum = {4'b0, r_wmax} + {1'b0, w_term};
                    n_wc    = (w_wcsum[35:32] != 4'd0) ? MAX32 : w_wcsum[31:0];
                end
                w_men   = 1'b1;
                w_ma    = r_wmax;
                w_mb    = RECIP5;
                n_state = ST_C_BASE;
            end

            ST_C_BASE: begin
                n_base = w_sev;
                if (r_srtt == 32'd0) begin
                    n_we    = MAX32;
                    n_state = ST_C_CMP;
                end else begin
                    w_dreq.start = 1'b1;
                    w_dreq.num   = r_dt;
                    w_dreq.den   = 64'(w_den17);
                    n_ret        = ST_C_FQ;
                    n_state      = ST_DWAIT;
                end
            end

            ST_C_FQ: begin
                if (w_drsp.quot[63:16] != 48'd0) begin
                    n_we    = MAX32;
                    n_state = ST_C_CMP;
                end else begin
                    n_fq         = w_drsp.quot[15:0];
                    w_dreq.start = 1'b1;
                    w_dreq.num   = {7'b0, w_rem9, 16'b0};
                    w_dreq.den   = 64'(w_den17);
                    n_ret        = ST_C_FR;
                    n_state      = ST_DWAIT;
                end
            end

            ST_C_FR: begin
                w_fterm = {1'b0, w_fq9, 16'b0} + {17'b0, w_drsp.quot[19:0]};
                w_wesum = {6'b0, r_base} + {1'b0, w_fterm};
                n_we    = (w_wesum[37:32] != 6'd0) ? MAX32 : w_wesum[31:0];
                n_state = ST_C_CMP;
            end

            // Pick the region; cubic steps by (W - cwnd) / cwnd.
            ST_C_CMP: begin
                if (r_wc < r_we) begin
                    n_cur    = r_we;
                    n_region = RG_FRIENDLY;
                    n_state  = ST_DONE;
                end else begin
                    if (r_wc >= r_cur) begin
                        w_diff = r_wc - r_cur;
                        n_neg  = 1'b0;
                    end else begin
                        w_diff = r_cur - r_wc;
                        n_neg  = 1'b1;
                    end
                    w_dreq.start = 1'b1;
                    w_dreq.num   = {16'b0, w_diff, 16'b0};
                    w_dreq.den   = {32'b0, (r_cur == 32'd0) ? 32'd1 : r_cur};
                    n_ret        = ST_C_STEP;
                    n_state      = ST_DWAIT;
                end
            end

            ST_C_STEP: begin
                w_mag = w_drsp.quot[48:0];
                if (r_neg) begin
                    n_cur = ({17'b0, r_cur} < w_mag) ? 32'd0 : r_cur - w_mag[31:0];
                end else begin
                    w_stsum = {18'b0, r_cur} + {1'b0, w_mag};
                    n_cur   = (w_stsum[49:32] != 18'd0) ? MAX32 : w_stsum[31:0];
                end
                n_region = RG_CUBIC;
                n_state  = ST_DONE;
            end

            // Hand the result to the output register once it is free.
            ST_DONE: begin
                if (!r_ov || m_axis_tready) begin
                    n_ov    = 1'b1;
                    n_ow    = r_cur;
                    n_or    = r_region;
                    n_state = ST_IDLE;
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_ret   <= ST_IDLE;
            r_tick  <= TICK_RESET;
            r_epoch <= '0;
            r_cur   <= TWO_Q16;
            r_wmax  <= '0;
            r_k     <= '0;
            r_ssl   <= MAX32;
            r_iter  <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ret   <= n_ret;
            r_tick  <= n_tick;
            r_epoch <= n_epoch;
            r_cur   <= n_cur;
            r_wmax  <= n_wmax;
            r_k     <= n_k;
            r_ssl   <= n_ssl;
            r_iter  <= n_iter;
            r_ov    <= n_ov;
        end
        r_now    <= n_now;
        r_srtt   <= n_srtt;
        r_dt     <= n_dt;
        r_nh     <= n_nh;
        r_y      <= n_y;
        r_upd    <= n_upd;
        r_tq     <= n_tq;
        r_neg    <= n_neg;
        r_a      <= n_a;
        r_s2     <= n_s2;
        r_qh     <= n_qh;
        r_wc     <= n_wc;
        r_base   <= n_base;
        r_fq     <= n_fq;
        r_we     <= n_we;
        r_region <= n_region;
        r_ow     <= n_ow;
        r_or     <= n_or;
    end

    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = r_ow;
    assign m_axis_tuser  = r_or;

endmodule

// File: sv/ccw_checker.sv
// Port checker for the CUBIC congestion window top level, with its bind.
// Depends on ccw_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "cubic_congestion_window_top_assert.svh"

module ccw_checker
    import ccw_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata,
    input logic [1:0]  m_axis_tuser
);

    // A stalled result beat keeps its payload.
    `CCW_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "stalled result changed")

    // The block works on one item at a time.
    `CCW_ASSERT_NEXT(a_busy_after_accept, s_axis_tvalid && s_axis_tready, !s_axis_tready, "input accepted while busy")

    // No result is pending right after reset.
    `CCW_ASSERT_ALWAYS(a_reset_empty, !i_rst_n, !m_axis_tvalid, "result valid after reset")

    // A slow start result is at least one segment.
    `CCW_ASSERT_NOW(a_slow_floor, m_axis_tvalid && m_axis_tuser == RG_SLOW, m_axis_tdata[31:16] != 16'd0, "slow start window below one segment")

endmodule

bind cubic_congestion_window_top ccw_checker u_ccw_checker (.*);

// File: sim/testbench.sv
// Self-checking testbench for cubic_congestion_window_top: ack and loss beats with
// random timing and stalls, predicted by an in-bench Q16.16 CUBIC window model.
// Depends on ccw_pkg and the block RTL only.
`timescale 1ns / 1ps

module testbench;
    import ccw_pkg::*;

    localparam longint CYCLE_LIMIT = 8_000_000;

    // Expected window and region of one result beat.
    typedef struct {
        logic [31:0] window;
        t_region     region;
    } t_window_result;

    // Scoreboard holding its own copy of the window state.
    class window_scoreboard;
        bit [63:0] tick_rate;
        bit [63:0] epoch;
        bit [63:0] window;
        bit [63:0] wmax;
        bit [63:0] k_q16;
        bit [63:0] ss_limit;
        t_window_result pending[$];
        int mismatches;

        function void reset_state();
            tick_rate = 64'd1000000000;
            epoch     = 0;
            window    = 64'h20000;
            wmax      = 0;
            k_q16     = 0;
            ss_limit  = 64'hFFFF_FFFF;
            pending.delete();
            mismatches = 0;
        endfunction

        function void set_rate(logic [31:0] r);
            tick_rate = {32'd0, r};
        endfunction

        function bit [63:0] sat32(longint v);
            if (v < 0) return 0;
            if (v > 64'shFFFF_FFFF) return 64'hFFFF_FFFF;
            return v;
        endfunction

        // Newton iteration for the integer cube root.
        function bit [63:0] icbrt(bit [63:0] n);
            int nbits;
            bit [63:0] m, y, nx;
            if (n == 0) return 0;
            nbits = 0;
            m = n;
            while (m != 0) begin
                nbits++;
                m >>= 1;
            end
            y = 64'd1 << ((nbits + 2) / 3);
            for (int i = 0; i < CBRT_ITERATIONS; i++) begin
                nx = (2 * y + n / (y * y)) / 3;
                if (nx < y && nx != 0) y = nx;
            end
            return y;
        endfunction

        function void note_input(logic mode, logic [63:0] now, logic [31:0] srtt);
            t_window_result res;
            bit [63:0] rate, dt, whole, rem, t_q, a, sq, term, base, den, q, r;
            longint tk, wc, we, div, step;
            if (mode) begin
                epoch    = now;
                wmax     = window;
                k_q16    = icbrt((wmax * 3 / 4) << 32) & 64'hFFFF_FFFF;
                window   = window * 7 / 10;
                ss_limit = (window > 64'h20000) ? window : 64'h20000;
                res.region = RG_DECREASE;
            end else if (window < ss_limit) begin
                window = sat32(window + 64'h10000);
                res.region = RG_SLOW;
            end else begin
                rate  = (tick_rate == 0) ? 1 : tick_rate;
                dt    = now - epoch;
                whole = dt / rate;
                rem   = dt % rate;
                t_q   = (whole > 64'hFFFF_FFFF) ? (64'd1 << 48)
                                                : (whole << 16) + (rem << 16) / rate;
                // Cubic target with |t - K| clamped to 64 seconds.
                tk = longint'(t_q) - longint'(k_q16);
                a  = (tk < 0) ? -tk : tk;
                if (a > (64'd64 << 16)) a = 64'd64 << 16;
                sq   = (a * a) >> 16;
                term = (((sq * a) >> 16) * 2) / 5;
                wc = (tk < 0) ? sat32(longint'(wmax) - longint'(term))
                              : sat32(longint'(wmax) + longint'(term));
                // TCP-friendly estimate.
                base = wmax * 7 / 10;
                if (srtt == 0) begin
                    we = 64'hFFFF_FFFF;
                end else begin
                    den = 17 * {32'd0, srtt};
                    q = dt / den;
                    r = dt % den;
                    if (q >= 64'h10000) we = 64'hFFFF_FFFF;
                    else we = sat32(base + ((q * 9) << 16) + (r * 9 * 64'h10000) / den);
                end
                if (wc < we) begin
                    window = we;
                    res.region = RG_FRIENDLY;
                end else begin
                    div  = (window == 0) ? 1 : longint'(window);
                    step = ((wc - longint'(window)) * 65536) / div;
                    window = sat32(longint'(window) + step);
                    res.region = RG_CUBIC;
                end
            end
            res.window = window[31:0];
            pending.push_back(res);
        endfunction

        function void check(logic [31:0] window_out, logic [1:0] region_out);
            t_window_result exp_res;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: unexpected result window=%h region=%0d",
                             window_out, region_out);
                return;
            end
            exp_res = pending.pop_front();
            if (window_out !== exp_res.window || region_out !== exp_res.region) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: window exp %h got %h, region exp %0d got %0d",
                             exp_res.window, window_out, exp_res.region, region_out);
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [31:0] i_cfg_wdata = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [95:0] s_axis_tdata = '0;   // now_ticks [63:0], srtt_ticks [95:64]
    logic [0:0]  s_axis_tuser = '0;   // mode [0]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;        // window [31:0]
    logic [1:0]  m_axis_tuser;        // region [1:0]

    window_scoreboard sb = new();
    bit        idle_on = 1'b1;
    int        hold_cycles = 0;
    int        rx_gap = 0;
    longint    cycle_count = 0;
    logic [63:0] last_now = 0;

    cubic_congestion_window_top dut (.*);

    always #1 i_clk = ~i_clk;

    // Watchdog.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAIL cubic_congestion_window_top");
            $finish;
        end
    end

    // Result monitor.
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check(m_axis_tdata, m_axis_tuser);
    end

    // Receiver: random stall bursts, plus a long hold-off when requested.
    always @(negedge i_clk) begin
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            m_axis_tready <= 1'b0;
        end else if (rx_gap > 0) begin
            rx_gap <= rx_gap - 1;
            m_axis_tready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 7) == 0) begin
            rx_gap <= $urandom_range(0, 13);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // Offer one beat, starting and ending at a falling edge.
    task automatic send_event(logic mode, logic [63:0] now, logic [31:0] srtt);
        if (idle_on && $urandom_range(0, 5) == 0) begin
            s_axis_tvalid = 1'b0;
            repeat ($urandom_range(1, 14)) @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = {srtt, now};
        s_axis_tuser  = mode;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        sb.note_input(mode, now, srtt);
        @(negedge i_clk);
    endtask

    // Wait until every result is in, then write the tick rate.
    task automatic write_rate(logic [31:0] rate);
        s_axis_tvalid = 1'b0;
        while (sb.pending.size() != 0) @(negedge i_clk);
        repeat (10) @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_wdata = rate;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        sb.set_rate(rate);
    endtask

    // Random event: mostly plausible timestamps advancing from the last one.
    task automatic random_event();
        logic        mode;
        logic [63:0] now;
        logic [31:0] srtt;
        mode = ($urandom_range(0, 99) < 15);
        if ($urandom_range(0, 19) == 0)
            now = {$urandom, $urandom};
        else
            now = last_now + ({32'd0, $urandom} >> $urandom_range(0, 31));
        case ($urandom_range(0, 19))
            0:       srtt = 0;
            1, 2:    srtt = $urandom;
            default: srtt = $urandom >> $urandom_range(4, 31);
        endcase
        last_now = now;
        send_event(mode, now, srtt);
    endtask

    initial begin
        logic [31:0] rates[5];
        sb.reset_state();
        repeat (11) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // Directed: slow start, loss, zero RTT, saturation, timestamp wrap.
        send_event(1'b0, 64'd0, 32'd100);
        send_event(1'b0, 64'd10, 32'd100);
        send_event(1'b1, 64'd1000, 32'd0);
        send_event(1'b0, 64'd2000, 32'd0);
        send_event(1'b1, 64'd3000, 32'hFFFF_FFFF);
        send_event(1'b0, 64'd5, 32'd1000);
        send_event(1'b0, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF);
        send_event(1'b1, 64'd4000, 32'd1);
        send_event(1'b0, 64'd4000, 32'd1);
        send_event(1'b0, 64'd4000 + 64'd5_000_000_000, 32'd50_000_000);
        send_event(1'b1, 64'hFFFF_FFFF_0000_0000, 32'd5);
        send_event(1'b0, 64'hFFFF_FFFF_0000_1000, 32'd7);
        send_event(1'b0, 64'd3, 32'd1);
        last_now = 64'd3;
        write_rate(32'd1);
        send_event(1'b1, 64'd10, 32'd1);
        send_event(1'b0, 64'd12, 32'd1);
        send_event(1'b0, 64'd200, 32'h8000_0000);
        write_rate(32'hFFFF_FFFF);
        send_event(1'b0, 64'd300, 32'd3);
        send_event(1'b1, 64'd400, 32'd3);
        send_event(1'b0, 64'hFFFF_FFFF_FFFF, 32'd3);

        // Random phases across several tick rates; the last runs without idling.
        rates[0] = 32'd1000000000;
        rates[1] = 32'd1000;
        rates[2] = 32'hFFFF_FFFF;
        rates[3] = $urandom;
        rates[4] = 32'd1;
        for (int p = 0; p < 5; p++) begin
            write_rate(rates[p]);
            if (p == 4) idle_on = 1'b0;
            if (p == 1) hold_cycles = 6000;
            for (int n = 0; n < 120; n++) random_event();
        end

        s_axis_tvalid = 1'b0;
        while (sb.pending.size() != 0) @(negedge i_clk);
        repeat (3000) @(negedge i_clk);
        if (sb.mismatches == 0 && sb.pending.size() == 0)
            $display("PASS cubic_congestion_window_top");
        else
            $display("FAIL cubic_congestion_window_top");
        $finish;
    end
endmodule
